/* sv/v3n_pkg.sv */
// v3n_pkg: shared constants and payload words for vec3_normalize_core
// no dependencies
`timescale 1ns / 1ps

package v3n_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int OUT_WIDTH      = 16;
    localparam int UNIT_FRAC      = 14;
    localparam int EPS_WIDTH      = 16;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;

    typedef struct packed {
        logic signed [COMP_WIDTH_DEF-1:0] comp_x;
        logic signed [COMP_WIDTH_DEF-1:0] comp_y;
        logic signed [COMP_WIDTH_DEF-1:0] comp_z;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        was_degenerate;
    } t_out_word;

endpackage

/* sv/vec3_normalize_core.sv */
// vec3_normalize_core: 3d vector normalisation, signed q3.12 in, signed q1.14 out
// depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell
`timescale 1ns / 1ps

// channel  signals                          word
// in       i_in_valid / o_in_ready          v3n_pkg::t_in_word
// out      o_out_valid / i_out_ready        v3n_pkg::t_out_word
// cfg      i_cfg_valid / o_cfg_ready        epsilon_length, 16 bits
//
// one word per cycle while the output is not stalled; the row is two input stages,
// 17 root cells, the length stage, 30 divide cells and the output register
// reset is synchronous; epsilon returns to 1
// a stalled output freezes the whole row; the input stalls only while it is frozen

module vec3_normalize_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  v3n_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output v3n_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [v3n_pkg::EPS_WIDTH-1:0] i_cfg_data
);
    localparam int MW = v3n_pkg::COMP_WIDTH_DEF;
    localparam int SW = 2 * MW + 2;
    localparam int RW = MW + 1;
    localparam int NS = RW;
    localparam int NW = MW + v3n_pkg::UNIT_FRAC;
    localparam int OW = v3n_pkg::OUT_WIDTH;
    localparam int LAT = 2 + NS + NW;
    localparam int CW = (RW > v3n_pkg::EPS_WIDTH) ? RW : v3n_pkg::EPS_WIDTH;

    logic [v3n_pkg::EPS_WIDTH-1:0] r_eps;
    logic       w_adv;
    logic       r_ovld;
    v3n_pkg::t_out_word r_oword;

    // the whole row moves together; a bubble shift register carries valid
    logic [LAT:0] r_vpipe;
    assign w_adv = !r_ovld || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= v3n_pkg::EPS_RESET;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_data;
        end
    end

    // magnitudes, signs and sum of squares
    logic [2:0][MW-1:0] w_raw;
    logic [2:0][MW-1:0] r_mag;
    logic [2:0]         r_neg;
    logic [SW-1:0]      w_sum;
    logic [SW-1:0]      r_sum;
    logic [2:0][MW-1:0] r_mag2;
    logic [2:0]         r_neg2;

    assign w_raw[0] = MW'(i_in_word.comp_x);
    assign w_raw[1] = MW'(i_in_word.comp_y);
    assign w_raw[2] = MW'(i_in_word.comp_z);

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < 3; c++) begin
            w_sum = w_sum + SW'({{MW{1'b0}}, r_mag[c]} * {{MW{1'b0}}, r_mag[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= w_raw[c][MW-1];
                r_mag[c] <= w_raw[c][MW-1] ? MW'(-w_raw[c]) : w_raw[c];
            end
            r_sum  <= w_sum;
            r_mag2 <= r_mag;
            r_neg2 <= r_neg;
        end
    end

    // square root row: cell g decides root bit NS-1-g, top bit first
    logic [NS:0][SW-1:0] w_srem;
    logic [NS:0][RW-1:0] w_sroot;
    logic [NS:0][2:0][MW-1:0] w_smag;
    logic [NS:0][2:0]    w_sneg;
    assign w_srem[0]  = r_sum;
    assign w_sroot[0] = '0;
    assign w_smag[0]  = r_mag2;
    assign w_sneg[0]  = r_neg2;

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        logic [2:0][MW-1:0] r_m;
        logic [2:0]         r_n;
        logic [SW-1:0]      w_or;
        logic [RW-1:0]      w_ot;
        v3n_sqrt_cell #(.SW(SW), .RW(RW), .K(NS-1-g)) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_rem   (w_srem[g]),
            .i_root  (w_sroot[g]),
            .o_rem   (w_or),
            .o_root  (w_ot)
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_m <= w_smag[g];
                r_n <= w_sneg[g];
            end
        end
        assign w_srem[g+1]  = w_or;
        assign w_sroot[g+1] = w_ot;
        assign w_smag[g+1]  = r_m;
        assign w_sneg[g+1]  = r_n;
    end

    // length stage and degenerate decision
    logic [RW-1:0]      r_len;
    logic [2:0][MW-1:0] r_dmag;
    logic [2:0]         r_dneg;
    logic               r_degen;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_len   <= w_sroot[NS];
            r_dmag  <= w_smag[NS];
            r_dneg  <= w_sneg[NS];
            r_degen <= (w_sroot[NS] == '0) || (CW'(w_sroot[NS]) < CW'(r_eps));
        end
    end

    // divide row
    logic [NW:0][RW-1:0]         w_den;
    logic [NW:0][2:0][NW-1:0]    w_drem;
    logic [NW:0][2:0][NW-1:0]    w_dquo;
    logic [NW:0][2:0]            w_dn;
    logic [NW:0]                 w_dg;
    assign w_den[0] = r_len;
    for (genvar c = 0; c < 3; c++) begin : g_num
        assign w_drem[0][c] = {r_dmag[c], {v3n_pkg::UNIT_FRAC{1'b0}}};
    end
    assign w_dquo[0] = '0;
    assign w_dn[0]   = r_dneg;
    assign w_dg[0]   = r_degen;

    for (genvar g = 0; g < NW; g++) begin : g_div
        logic [RW-1:0]         w_od;
        logic [2:0][NW-1:0]    w_or;
        logic [2:0][NW-1:0]    w_oq;
        logic [2:0]            r_n;
        logic                  r_g;
        v3n_div_cell #(.NW(NW), .DW(RW), .K(NW-1-g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_den (w_den[g]),
            .i_rem (w_drem[g]),
            .i_quo (w_dquo[g]),
            .o_den (w_od),
            .o_rem (w_or),
            .o_quo (w_oq)
        );
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_n <= w_dn[g];
                r_g <= w_dg[g];
            end
        end
        assign w_den[g+1]  = w_od;
        assign w_drem[g+1] = w_or;
        assign w_dquo[g+1] = w_oq;
        assign w_dn[g+1]   = r_n;
        assign w_dg[g+1]   = r_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else if (w_adv) begin
            r_vpipe <= {r_vpipe[LAT-1:0], i_in_valid};
        end
    end

    function automatic logic [OW-1:0] f_fin(input logic [NW-1:0] q, input logic n, input logic d);
        logic [OW-1:0] m;
        m = (q > NW'(1 << v3n_pkg::UNIT_FRAC)) ? OW'(1 << v3n_pkg::UNIT_FRAC) : OW'(q);
        if (d) begin
            return '0;
        end
        return n ? OW'(-m) : m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= r_vpipe[LAT];
        end
        if (w_adv) begin
            r_oword.unit_x         <= f_fin(w_dquo[NW][0], w_dn[NW][0], w_dg[NW]);
            r_oword.unit_y         <= f_fin(w_dquo[NW][1], w_dn[NW][1], w_dg[NW]);
            r_oword.unit_z         <= f_fin(w_dquo[NW][2], w_dn[NW][2], w_dg[NW]);
            r_oword.was_degenerate <= w_dg[NW];
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_oword;
endmodule

/* sv/v3n_sqrt_cell.sv */
// v3n_sqrt_cell: one restoring square root step, registered
// no dependencies
`timescale 1ns / 1ps

module v3n_sqrt_cell #(
    parameter int SW = 36,
    parameter int RW = 18,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    output logic [SW-1:0] o_rem,
    output logic [RW-1:0] o_root
);
    // trial (2r + 2^k) << k compared against the remainder
    logic [SW+1:0] w_trial;
    logic [SW-1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [SW-1:0] r_rem;
    logic [RW-1:0] r_root;

    always_comb begin
        w_trial = ({{(SW+2-RW){1'b0}}, i_root} << (K + 1)) | ((SW+2)'(1) << (2 * K));
        n_rem   = i_rem;
        n_root  = i_root;
        if ({2'b00, i_rem} >= w_trial) begin
            n_rem  = i_rem - w_trial[SW-1:0];
            n_root = i_root | (RW'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

/* sv/v3n_div_cell.sv */
// v3n_div_cell: one restoring division step on three numerators, registered
// no dependencies
`timescale 1ns / 1ps

module v3n_div_cell #(
    parameter int NW = 30,
    parameter int DW = 17,
    parameter int K  = 0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DW-1:0]      i_den,
    input  logic [2:0][NW-1:0] i_rem,
    input  logic [2:0][NW-1:0] i_quo,
    output logic [DW-1:0]      o_den,
    output logic [2:0][NW-1:0] o_rem,
    output logic [2:0][NW-1:0] o_quo
);
    logic [NW+DW-1:0]   w_sh;
    logic [2:0][NW-1:0] n_rem;
    logic [2:0][NW-1:0] n_quo;
    logic [DW-1:0]      r_den;
    logic [2:0][NW-1:0] r_rem;
    logic [2:0][NW-1:0] r_quo;

    always_comb begin
        w_sh = {{NW{1'b0}}, i_den} << K;
        for (int c = 0; c < 3; c++) begin
            n_rem[c] = i_rem[c];
            n_quo[c] = i_quo[c];
            if ({{DW{1'b0}}, i_rem[c]} >= w_sh) begin
                n_rem[c] = i_rem[c] - w_sh[NW-1:0];
                n_quo[c] = i_quo[c] | (NW'(1) << K);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule
